[hw/rtl/pfgs_pkg.sv]
// Shared types, constants and rounding helper for the 3x3 gradient stencil.
// No dependencies; used by pfgs_line_ram and phase_field_gradient_stencil_core.
`default_nettype none

package pfgs_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int LINE_W      = 2 * SAMPLE_BITS;
    localparam int ROW_W       = 16;
    localparam int WIDTH_W     = 11;
    localparam int SCALE_W     = 24;
    localparam int DIFF_W      = SAMPLE_BITS + 2;
    localparam int PROD_W      = DIFF_W + SCALE_W + 1;
    localparam int RES_W       = 32;
    localparam int NUM_DER     = 10;
    localparam int DER_IDX_W   = $clog2(NUM_DER);

    localparam logic [SCALE_W-1:0] INV_SPACING_RST = SCALE_W'(4096);
    localparam logic [WIDTH_W-1:0] GRID_WIDTH_RST  = WIDTH_W'(1024);
    localparam logic [ROW_W-1:0]   GRID_HEIGHT_RST = ROW_W'(1024);
    localparam logic [WIDTH_W-1:0] MIN_EXTENT      = WIDTH_W'(3);

    typedef enum logic [1:0] {
        CFG_INV_X  = 2'd0,
        CFG_INV_Y  = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SH_PLAIN   = 2'd0,
        SH_CENTRAL = 2'd1,
        SH_FACE    = 2'd2
    } t_shift;

    // derivative slots, in result field order
    localparam logic [DER_IDX_W-1:0] D_X_RIGHT   = DER_IDX_W'(0);
    localparam logic [DER_IDX_W-1:0] D_X_LEFT    = DER_IDX_W'(1);
    localparam logic [DER_IDX_W-1:0] D_Y_TOP     = DER_IDX_W'(2);
    localparam logic [DER_IDX_W-1:0] D_Y_BOTTOM  = DER_IDX_W'(3);
    localparam logic [DER_IDX_W-1:0] D_X_CENTRAL = DER_IDX_W'(4);
    localparam logic [DER_IDX_W-1:0] D_Y_CENTRAL = DER_IDX_W'(5);
    localparam logic [DER_IDX_W-1:0] D_X_UPPER   = DER_IDX_W'(6);
    localparam logic [DER_IDX_W-1:0] D_X_LOWER   = DER_IDX_W'(7);
    localparam logic [DER_IDX_W-1:0] D_Y_RIGHT   = DER_IDX_W'(8);
    localparam logic [DER_IDX_W-1:0] D_Y_LEFT    = DER_IDX_W'(9);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [RES_W-1:0]       t_res;

    function automatic logic der_is_y(input logic [DER_IDX_W-1:0] k);
        logic y;
        case (k)
            D_Y_TOP, D_Y_BOTTOM, D_Y_CENTRAL, D_Y_RIGHT, D_Y_LEFT: y = 1'b1;
            default: y = 1'b0;
        endcase
        return y;
    endfunction

    function automatic t_shift der_shift(input logic [DER_IDX_W-1:0] k);
        t_shift sh;
        case (k)
            D_X_RIGHT, D_X_LEFT, D_Y_TOP, D_Y_BOTTOM: sh = SH_PLAIN;
            D_X_CENTRAL, D_Y_CENTRAL:                 sh = SH_CENTRAL;
            default:                                  sh = SH_FACE;
        endcase
        return sh;
    endfunction

    // round half toward +inf, then saturate to 32 bits
    function automatic t_res round_sat(input t_prod p, input t_shift sh);
        t_prod q;
        t_prod hi;
        t_prod lo;
        t_res  r;
        hi = PROD_W'(64'sd2147483647);
        lo = -PROD_W'(64'sd2147483648);
        case (sh)
            SH_PLAIN:   q = (p + PROD_W'(64'sd2048)) >>> 12;
            SH_CENTRAL: q = (p + PROD_W'(64'sd4096)) >>> 13;
            SH_FACE:    q = (p + PROD_W'(64'sd8192)) >>> 14;
            default:    q = (p + PROD_W'(64'sd2048)) >>> 12;
        endcase
        if (q > hi) begin
            r = t_res'(hi);
        end else if (q < lo) begin
            r = t_res'(lo);
        end else begin
            r = t_res'(q);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/pfgs_line_ram.sv]
// Line memory holding the two previous rows per column as {far, near}.
// Synchronous registered read (enabled), one write port. Uses pfgs_pkg.
`default_nettype none

module pfgs_line_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_rd_en,
    input  wire logic [pfgs_pkg::ADDR_W-1:0] i_rd_addr,
    output logic      [pfgs_pkg::LINE_W-1:0] o_rd_data,
    input  wire logic                        i_wr_en,
    input  wire logic [pfgs_pkg::ADDR_W-1:0] i_wr_addr,
    input  wire logic [pfgs_pkg::LINE_W-1:0] i_wr_data
);

    logic [pfgs_pkg::LINE_W-1:0] mem [pfgs_pkg::MAX_WIDTH];
    logic [pfgs_pkg::LINE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hw/rtl/phase_field_gradient_stencil_core.sv]
// Top level: raster-stream 3x3 finite-difference gradient stencil.
// Depends on pfgs_pkg and pfgs_line_ram.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_phi_sample
//  out     | source    | o_out_valid / i_out_stall  | o_der_* (10 x 32b), o_end_of_frame
//  cfg     | sink      | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One sample per cycle sustained unless the output stalls; an input transaction reaches
// the output via the line memory read, window, multiply and round/saturate registers.
// A column's line memory entry is read at accept and rewritten as the transaction
// enters the window; the same column recurs no sooner than three transactions on.
// Synchronous active-low reset clears positions, window and stage valids; input stalls.
// A stage advances when the next is empty or moving, so bubbles fill behind a stall.
`default_nettype none

module phase_field_gradient_stencil_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [1:0]                       i_cfg_idx,
    input  wire logic [pfgs_pkg::SCALE_W-1:0]     i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [pfgs_pkg::SAMPLE_BITS-1:0] i_phi_sample,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [pfgs_pkg::RES_W-1:0]       o_der_x_right,
    output logic      [pfgs_pkg::RES_W-1:0]       o_der_x_left,
    output logic      [pfgs_pkg::RES_W-1:0]       o_der_y_top,
    output logic      [pfgs_pkg::RES_W-1:0]       o_der_y_bottom,
    output logic      [pfgs_pkg::RES_W-1:0]       o_der_x_central,
    output logic      [pfgs_pkg::RES_W-1:0]       o_der_y_central,
    output logic      [pfgs_pkg::RES_W-1:0]       o_der_x_upper_face,
    output logic      [pfgs_pkg::RES_W-1:0]       o_der_x_lower_face,
    output logic      [pfgs_pkg::RES_W-1:0]       o_der_y_right_face,
    output logic      [pfgs_pkg::RES_W-1:0]       o_der_y_left_face,
    output logic                                  o_end_of_frame
);

    // configuration
    logic [pfgs_pkg::SCALE_W-1:0] r_inv_x;
    logic [pfgs_pkg::SCALE_W-1:0] r_inv_y;
    logic [pfgs_pkg::WIDTH_W-1:0] r_grid_w;
    logic [pfgs_pkg::ROW_W-1:0]   r_grid_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_x  <= pfgs_pkg::INV_SPACING_RST;
            r_inv_y  <= pfgs_pkg::INV_SPACING_RST;
            r_grid_w <= pfgs_pkg::GRID_WIDTH_RST;
            r_grid_h <= pfgs_pkg::GRID_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (pfgs_pkg::t_cfg_idx'(i_cfg_idx))
                pfgs_pkg::CFG_INV_X:  r_inv_x  <= i_cfg_data;
                pfgs_pkg::CFG_INV_Y:  r_inv_y  <= i_cfg_data;
                pfgs_pkg::CFG_WIDTH:  r_grid_w <= i_cfg_data[pfgs_pkg::WIDTH_W-1:0];
                pfgs_pkg::CFG_HEIGHT: r_grid_h <= i_cfg_data[pfgs_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // stage enables
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_o_vld;
    logic r_s1_emit;
    logic en_o, en3, en2, en1, accept, fire1;

    assign en_o   = !r_o_vld || !i_out_stall;
    assign en3    = !r_s3_vld || en_o;
    assign en2    = !r_s2_vld || en3;
    assign en1    = !r_s1_vld || !r_s1_emit || en2;
    assign o_in_stall = !en1 || !i_rst_n;
    assign accept = i_in_valid && !o_in_stall;
    assign fire1  = r_s1_vld && en1;

    // raster position
    logic [pfgs_pkg::ADDR_W-1:0]  r_col, n_col;
    logic [pfgs_pkg::ROW_W-1:0]   r_row, n_row;
    logic [pfgs_pkg::WIDTH_W-1:0] w_eff;
    logic [pfgs_pkg::ROW_W-1:0]   h_eff;
    logic                         last_col, last_row;

    always_comb begin
        if (r_grid_w < pfgs_pkg::MIN_EXTENT) begin
            w_eff = pfgs_pkg::MIN_EXTENT;
        end else if (r_grid_w > pfgs_pkg::WIDTH_W'(pfgs_pkg::MAX_WIDTH)) begin
            w_eff = pfgs_pkg::WIDTH_W'(pfgs_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_grid_w;
        end
        if (r_grid_h < pfgs_pkg::ROW_W'(pfgs_pkg::MIN_EXTENT)) begin
            h_eff = pfgs_pkg::ROW_W'(pfgs_pkg::MIN_EXTENT);
        end else begin
            h_eff = r_grid_h;
        end
        last_col = pfgs_pkg::WIDTH_W'(r_col) >= (w_eff - pfgs_pkg::WIDTH_W'(1));
        last_row = r_row >= (h_eff - pfgs_pkg::ROW_W'(1));
        n_col = r_col + pfgs_pkg::ADDR_W'(1);
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + pfgs_pkg::ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1: line memory data available
    logic                              r_s1_eof;
    logic [pfgs_pkg::ADDR_W-1:0]       r_s1_col;
    pfgs_pkg::t_sample                 r_s1_smp;
    logic [pfgs_pkg::LINE_W-1:0]       rd_line;

    pfgs_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_line),
        .i_wr_en   (fire1),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({rd_line[pfgs_pkg::SAMPLE_BITS-1:0], r_s1_smp})
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en1) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_smp  <= pfgs_pkg::t_sample'(i_phi_sample);
            r_s1_col  <= r_col;
            r_s1_emit <= (r_col >= pfgs_pkg::ADDR_W'(2)) && (r_row >= pfgs_pkg::ROW_W'(2));
            r_s1_eof  <= last_col && last_row;
        end
    end

    // 3x3 window: row 0 far, row 1 near, row 2 newest; column 2 newest
    pfgs_pkg::t_sample r_win [3][3];
    pfgs_pkg::t_sample n_win [3][3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = pfgs_pkg::t_sample'(rd_line[pfgs_pkg::LINE_W-1:pfgs_pkg::SAMPLE_BITS]);
        n_win[1][2] = pfgs_pkg::t_sample'(rd_line[pfgs_pkg::SAMPLE_BITS-1:0]);
        n_win[2][2] = r_s1_smp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (fire1) begin
            r_win <= n_win;
        end
    end

    // differences on the updated window
    pfgs_pkg::t_diff dc, de, dw, dn, ds, dne, dnw, dse, dsw;
    pfgs_pkg::t_diff n_diff [pfgs_pkg::NUM_DER];

    always_comb begin
        dsw = pfgs_pkg::DIFF_W'(n_win[0][0]);
        ds  = pfgs_pkg::DIFF_W'(n_win[0][1]);
        dse = pfgs_pkg::DIFF_W'(n_win[0][2]);
        dw  = pfgs_pkg::DIFF_W'(n_win[1][0]);
        dc  = pfgs_pkg::DIFF_W'(n_win[1][1]);
        de  = pfgs_pkg::DIFF_W'(n_win[1][2]);
        dnw = pfgs_pkg::DIFF_W'(n_win[2][0]);
        dn  = pfgs_pkg::DIFF_W'(n_win[2][1]);
        dne = pfgs_pkg::DIFF_W'(n_win[2][2]);
        n_diff[pfgs_pkg::D_X_RIGHT]   = de - dc;
        n_diff[pfgs_pkg::D_X_LEFT]    = dc - dw;
        n_diff[pfgs_pkg::D_Y_TOP]     = dn - dc;
        n_diff[pfgs_pkg::D_Y_BOTTOM]  = dc - ds;
        n_diff[pfgs_pkg::D_X_CENTRAL] = de - dw;
        n_diff[pfgs_pkg::D_Y_CENTRAL] = dn - ds;
        n_diff[pfgs_pkg::D_X_UPPER]   = de + dne - dw - dnw;
        n_diff[pfgs_pkg::D_X_LOWER]   = de + dse - dw - dsw;
        n_diff[pfgs_pkg::D_Y_RIGHT]   = dn + dne - ds - dse;
        n_diff[pfgs_pkg::D_Y_LEFT]    = dn + dnw - ds - dsw;
    end

    // stage 2: registered differences
    pfgs_pkg::t_diff r_s2_diff [pfgs_pkg::NUM_DER];
    logic            r_s2_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en2) begin
            r_s2_vld <= fire1 && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && fire1 && r_s1_emit) begin
            r_s2_diff <= n_diff;
            r_s2_eof  <= r_s1_eof;
        end
    end

    // stage 3: products
    pfgs_pkg::t_prod r_s3_prod [pfgs_pkg::NUM_DER];
    pfgs_pkg::t_prod n_prod    [pfgs_pkg::NUM_DER];
    logic            r_s3_eof;

    always_comb begin
        for (int k = 0; k < pfgs_pkg::NUM_DER; k++) begin
            n_prod[k] = pfgs_pkg::PROD_W'(r_s2_diff[k] * $signed({1'b0,
                pfgs_pkg::der_is_y(pfgs_pkg::DER_IDX_W'(k)) ? r_inv_y : r_inv_x}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en3) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_s2_vld) begin
            r_s3_prod <= n_prod;
            r_s3_eof  <= r_s2_eof;
        end
    end

    // output register: round and saturate
    pfgs_pkg::t_res r_o_der [pfgs_pkg::NUM_DER];
    pfgs_pkg::t_res n_der   [pfgs_pkg::NUM_DER];
    logic           r_o_eof;

    always_comb begin
        for (int k = 0; k < pfgs_pkg::NUM_DER; k++) begin
            n_der[k] = pfgs_pkg::round_sat(r_s3_prod[k],
                                           pfgs_pkg::der_shift(pfgs_pkg::DER_IDX_W'(k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en_o) begin
            r_o_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o && r_s3_vld) begin
            r_o_der <= n_der;
            r_o_eof <= r_s3_eof;
        end
    end

    assign o_out_valid        = r_o_vld;
    assign o_der_x_right      = r_o_der[pfgs_pkg::D_X_RIGHT];
    assign o_der_x_left       = r_o_der[pfgs_pkg::D_X_LEFT];
    assign o_der_y_top        = r_o_der[pfgs_pkg::D_Y_TOP];
    assign o_der_y_bottom     = r_o_der[pfgs_pkg::D_Y_BOTTOM];
    assign o_der_x_central    = r_o_der[pfgs_pkg::D_X_CENTRAL];
    assign o_der_y_central    = r_o_der[pfgs_pkg::D_Y_CENTRAL];
    assign o_der_x_upper_face = r_o_der[pfgs_pkg::D_X_UPPER];
    assign o_der_x_lower_face = r_o_der[pfgs_pkg::D_X_LOWER];
    assign o_der_y_right_face = r_o_der[pfgs_pkg::D_Y_RIGHT];
    assign o_der_y_left_face  = r_o_der[pfgs_pkg::D_Y_LEFT];
    assign o_end_of_frame     = r_o_eof;

endmodule

`default_nettype wire
